/* rtl/point_segment_distance_macros.svh */
// Assertion macros for the point-to-segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_MACROS_SVH

`ifndef ASSERT_OFF
`define PSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PSD_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PSD_ASSERT(label, clk, rst_n, prop)
`define PSD_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/psd_pkg.sv */
`default_nettype none
package psd_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int DIST_W    = 25;
  localparam int NEAR_W    = 24;
  localparam int DEN_W     = 34;
  localparam int QUO_W     = 50;
  localparam int NUM_W     = DEN_W + QUO_W;
  localparam int ROOT_W    = 25;
  localparam int SREM_W    = 27;
  localparam int DIV_CELLS  = QUO_W;
  localparam int SQRT_CELLS = ROOT_W;

  typedef enum logic [1:0] {
    REG_START    = 2'd0,
    REG_END      = 2'd1,
    REG_INTERIOR = 2'd2
  } region_t;

  // one division step of three lanes sharing a divisor
  typedef struct packed {
    logic                  valid;
    logic [DEN_W-1:0]      den;
    logic [NUM_W-1:0]      acc_c;
    logic [NUM_W-1:0]      acc_x;
    logic [NUM_W-1:0]      acc_y;
    region_t               region;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
  } div_stage_t;

  typedef struct packed {
    logic                  valid;
    logic [2*ROOT_W-1:0]   rad;
    logic [SREM_W-1:0]     rem;
    logic [ROOT_W-1:0]     root;
    region_t               region;
    logic [NEAR_W-1:0]     near_x;
    logic [NEAR_W-1:0]     near_y;
  } sqrt_stage_t;

endpackage
`default_nettype wire

/* rtl/psd_front.sv */
`default_nettype none
module psd_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [psd_pkg::COORD_W-1:0] sx,
  input  wire logic signed [psd_pkg::COORD_W-1:0] sy,
  input  wire logic signed [psd_pkg::COORD_W-1:0] ex,
  input  wire logic signed [psd_pkg::COORD_W-1:0] ey,
  input  wire logic signed [psd_pkg::COORD_W-1:0] qx,
  input  wire logic signed [psd_pkg::COORD_W-1:0] qy,
  output psd_pkg::div_stage_t                    front_out
);

  // stage A: differences
  logic               va_r;
  logic signed [16:0] dx_r, dy_r, px_r, py_r, rx_r, ry_r;
  logic [15:0]        sx_a_r, sy_a_r, ex_a_r, ey_a_r;

  // stage B: products
  logic               vb_r;
  logic signed [33:0] pdx_r, pdy_r, ddx_r, ddy_r, cxa_r, cxb_r;
  logic signed [33:0] ppx_r, ppy_r, rrx_r, rry_r;
  logic [16:0]        nax_b_r, nay_b_r;
  logic               ngx_b_r, ngy_b_r;
  logic [15:0]        sx_b_r, sy_b_r, ex_b_r, ey_b_r;

  // stage C: sums and region decision
  logic               vc_r;
  psd_pkg::region_t   reg_c_r, reg_c_nxt;
  logic [32:0]        dot_c_r, cm_c_r, d2_c_r;
  logic [33:0]        len2_c_r;
  logic [16:0]        nax_c_r, nay_c_r;
  logic               ngx_c_r, ngy_c_r;
  logic [15:0]        cx_c_r, cy_c_r;
  logic signed [34:0] dot_w, cross_w;
  logic [33:0]        len2_w;
  logic [32:0]        d2s_w, d2e_w;
  logic [34:0]        cabs_w;

  // stage D: squares of cross and foot numerators
  logic               vd_r;
  psd_pkg::region_t   reg_d_r;
  logic [31:0]        aa_r;
  logic [32:0]        ab_r;
  logic [33:0]        bb_r;
  logic [49:0]        fx_r, fy_r;
  logic [33:0]        len2_d_r;
  logic [32:0]        d2_d_r;
  logic               ngx_d_r, ngy_d_r;
  logic [15:0]        cx_d_r, cy_d_r;

  // stage E: numerators and divisor
  psd_pkg::div_stage_t e_r, e_nxt;
  logic [65:0]         c2_w;

  assign dot_w   = 35'(pdx_r) + 35'(pdy_r);
  assign len2_w  = {2'b0, ddx_r[31:0]} + {2'b0, ddy_r[31:0]};
  assign cross_w = 35'(cxa_r) - 35'(cxb_r);
  assign cabs_w  = cross_w[34] ? 35'(-cross_w) : 35'(cross_w);
  assign d2s_w   = {1'b0, ppx_r[31:0]} + {1'b0, ppy_r[31:0]};
  assign d2e_w   = {1'b0, rrx_r[31:0]} + {1'b0, rry_r[31:0]};

  always_comb begin
    if (len2_w == '0 || dot_w < 0) begin
      reg_c_nxt = psd_pkg::REG_START;
    end else if (dot_w[33:0] > len2_w) begin
      reg_c_nxt = psd_pkg::REG_END;
    end else begin
      reg_c_nxt = psd_pkg::REG_INTERIOR;
    end
  end

  assign c2_w = ({34'b0, aa_r} << 34) + ({33'b0, ab_r} << 18) + {32'b0, bb_r};

  always_comb begin
    e_nxt         = '0;
    e_nxt.valid   = vd_r;
    e_nxt.region  = reg_d_r;
    e_nxt.neg_x   = ngx_d_r;
    e_nxt.neg_y   = ngy_d_r;
    e_nxt.coord_x = cx_d_r;
    e_nxt.coord_y = cy_d_r;
    if (reg_d_r == psd_pkg::REG_INTERIOR) begin
      e_nxt.den   = len2_d_r;
      e_nxt.acc_c = {2'b0, c2_w, 16'b0};
      e_nxt.acc_x = {26'b0, fx_r, 8'b0};
      e_nxt.acc_y = {26'b0, fy_r, 8'b0};
    end else begin
      e_nxt.den   = 34'd1;
      e_nxt.acc_c = {35'b0, d2_d_r, 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      e_r  <= '0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      e_r  <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= 17'(ex) - 17'(sx);
      dy_r <= 17'(ey) - 17'(sy);
      px_r <= 17'(qx) - 17'(sx);
      py_r <= 17'(qy) - 17'(sy);
      rx_r <= 17'(qx) - 17'(ex);
      ry_r <= 17'(qy) - 17'(ey);
      sx_a_r <= sx;
      sy_a_r <= sy;
      ex_a_r <= ex;
      ey_a_r <= ey;

      pdx_r <= px_r * dx_r;
      pdy_r <= py_r * dy_r;
      ddx_r <= dx_r * dx_r;
      ddy_r <= dy_r * dy_r;
      cxa_r <= px_r * dy_r;
      cxb_r <= py_r * dx_r;
      ppx_r <= px_r * px_r;
      ppy_r <= py_r * py_r;
      rrx_r <= rx_r * rx_r;
      rry_r <= ry_r * ry_r;
      nax_b_r <= dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
      nay_b_r <= dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
      ngx_b_r <= dx_r[16];
      ngy_b_r <= dy_r[16];
      sx_b_r <= sx_a_r;
      sy_b_r <= sy_a_r;
      ex_b_r <= ex_a_r;
      ey_b_r <= ey_a_r;

      reg_c_r  <= reg_c_nxt;
      dot_c_r  <= dot_w[32:0];
      len2_c_r <= len2_w;
      cm_c_r   <= cabs_w[32:0];
      d2_c_r   <= (reg_c_nxt == psd_pkg::REG_END) ? d2e_w : d2s_w;
      nax_c_r  <= nax_b_r;
      nay_c_r  <= nay_b_r;
      ngx_c_r  <= ngx_b_r;
      ngy_c_r  <= ngy_b_r;
      cx_c_r   <= (reg_c_nxt == psd_pkg::REG_END) ? ex_b_r : sx_b_r;
      cy_c_r   <= (reg_c_nxt == psd_pkg::REG_END) ? ey_b_r : sy_b_r;

      reg_d_r  <= reg_c_r;
      aa_r     <= cm_c_r[32:17] * cm_c_r[32:17];
      ab_r     <= 33'(cm_c_r[32:17] * cm_c_r[16:0]);
      bb_r     <= cm_c_r[16:0] * cm_c_r[16:0];
      fx_r     <= dot_c_r * nax_c_r;
      fy_r     <= dot_c_r * nay_c_r;
      len2_d_r <= len2_c_r;
      d2_d_r   <= d2_c_r;
      ngx_d_r  <= ngx_c_r;
      ngy_d_r  <= ngy_c_r;
      cx_d_r   <= cx_c_r;
      cy_d_r   <= cy_c_r;
    end
  end

  assign front_out = e_r;

endmodule
`default_nettype wire

/* rtl/psd_div_cell.sv */
`default_nettype none
module psd_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire psd_pkg::div_stage_t d_in,
  output psd_pkg::div_stage_t      d_out
);

  psd_pkg::div_stage_t q_r, q_nxt;

  // shift in one dividend bit, subtract the divisor where it fits
  function automatic logic [psd_pkg::NUM_W-1:0] div_step(
    input logic [psd_pkg::NUM_W-1:0] acc,
    input logic [psd_pkg::DEN_W-1:0] den
  );
    logic [psd_pkg::DEN_W:0] r;
    logic                    ge;
    r  = acc[psd_pkg::NUM_W-1:psd_pkg::QUO_W-1];
    ge = (r >= {1'b0, den});
    if (ge) r = r - {1'b0, den};
    return {r[psd_pkg::DEN_W-1:0], acc[psd_pkg::QUO_W-2:0], ge};
  endfunction

  always_comb begin
    q_nxt       = d_in;
    q_nxt.acc_c = div_step(d_in.acc_c, d_in.den);
    q_nxt.acc_x = div_step(d_in.acc_x, d_in.den);
    q_nxt.acc_y = div_step(d_in.acc_y, d_in.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule
`default_nettype wire

/* rtl/psd_sqrt_cell.sv */
`default_nettype none
module psd_sqrt_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire psd_pkg::sqrt_stage_t s_in,
  output psd_pkg::sqrt_stage_t      s_out
);

  localparam int TW = psd_pkg::SREM_W + 2;

  psd_pkg::sqrt_stage_t q_r, q_nxt;
  logic [TW-1:0]        t_w, trial_w;
  logic                 ge_w;

  // bring down two radicand bits, try the next root bit
  assign t_w     = {s_in.rem, s_in.rad[2*psd_pkg::ROOT_W-1 -: 2]};
  assign trial_w = {2'b0, s_in.root, 2'b01};
  assign ge_w    = (t_w >= trial_w);

  always_comb begin
    q_nxt      = s_in;
    q_nxt.rem  = ge_w ? psd_pkg::SREM_W'(t_w - trial_w) : psd_pkg::SREM_W'(t_w);
    q_nxt.root = {s_in.root[psd_pkg::ROOT_W-2:0], ge_w};
    q_nxt.rad  = {s_in.rad[2*psd_pkg::ROOT_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign s_out = q_r;

endmodule
`default_nettype wire

/* rtl/point_segment_distance.sv */
`default_nettype none
`include "point_segment_distance_macros.svh"
// Point-to-segment distance. Each request carries a segment (start, end) and a
// query point as signed 16-bit coordinates; the block returns the truncated
// Euclidean distance (8 fraction bits), the nearest point on the segment
// (signed, 8 fraction bits, saturated) and a region code: start/degenerate,
// past end, or interior projection. One request is taken every cycle unless
// the row is frozen, and each result passes through 81 register stages: five
// front-end stages (differences, products, sums, cross square, numerator
// set-up), a row of 50 restoring-division cells, one stage that assembles
// the foot point, and a row of 25 square-root cells, each cell resolving one
// result bit. The whole row advances together; when the result register is
// held by the consumer the row freezes and in_tready drops in the same cycle.
module point_segment_distance (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
  // query_x[79:64], query_y[95:80]
  input  wire logic [95:0] in_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // distance[24:0], nearest_x[48:25], nearest_y[72:49], zero pad [79:73]
  output      logic [79:0] out_tdata,
  // region[1:0]
  output      logic [1:0]  out_tuser
);

  localparam int NW = psd_pkg::NEAR_W;

  logic                 en;
  psd_pkg::div_stage_t  div_chain [psd_pkg::DIV_CELLS+1];
  psd_pkg::sqrt_stage_t sqrt_chain [psd_pkg::SQRT_CELLS+1];
  psd_pkg::div_stage_t  dl_w;
  psd_pkg::sqrt_stage_t fin_r, fin_nxt;
  logic [NW-1:0]        near_x_w, near_y_w;
  logic                 dl_endpoint_w, dl_quo_zero_w;
  logic                 out_endpoint_w, out_whole_w;

  // advance the whole row unless a finished result is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .sx       (in_tdata[15:0]),
    .sy       (in_tdata[31:16]),
    .ex       (in_tdata[47:32]),
    .ey       (in_tdata[63:48]),
    .qx       (in_tdata[79:64]),
    .qy       (in_tdata[95:80]),
    .front_out(div_chain[0])
  );

  for (genvar i = 0; i < psd_pkg::DIV_CELLS; i++) begin : g_div
    psd_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .d_in (div_chain[i]),
      .d_out(div_chain[i+1])
    );
  end

  assign dl_w = div_chain[psd_pkg::DIV_CELLS];

  // foot point: base +/- quotient, floor toward minus infinity on negative axes
  function automatic logic [psd_pkg::NEAR_W-1:0] foot(
    input logic [psd_pkg::COORD_W-1:0] coord,
    input logic                        neg,
    input logic                        interior,
    input logic [psd_pkg::NUM_W-1:0]   acc
  );
    logic signed [26:0] base;
    logic signed [26:0] off;
    logic signed [26:0] v;
    logic               rem_nz;
    base   = 27'(signed'({coord, {psd_pkg::FRAC_BITS{1'b0}}}));
    off    = 27'({1'b0, acc[25:0]});
    rem_nz = (acc[psd_pkg::NUM_W-1:psd_pkg::QUO_W] != '0);
    if (!interior)  v = base;
    else if (neg)   v = base - off - 27'(rem_nz);
    else            v = base + off;
    if (v > 27'sd8388607)        return {1'b0, {(psd_pkg::NEAR_W-1){1'b1}}};
    else if (v < -27'sd8388608)  return {1'b1, {(psd_pkg::NEAR_W-1){1'b0}}};
    else                         return v[psd_pkg::NEAR_W-1:0];
  endfunction

  assign near_x_w = foot(dl_w.coord_x, dl_w.neg_x,
                         dl_w.region == psd_pkg::REG_INTERIOR, dl_w.acc_x);
  assign near_y_w = foot(dl_w.coord_y, dl_w.neg_y,
                         dl_w.region == psd_pkg::REG_INTERIOR, dl_w.acc_y);

  always_comb begin
    fin_nxt        = '0;
    fin_nxt.valid  = dl_w.valid;
    fin_nxt.rad    = dl_w.acc_c[psd_pkg::QUO_W-1:0];
    fin_nxt.region = dl_w.region;
    fin_nxt.near_x = near_x_w;
    fin_nxt.near_y = near_y_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= '0;
    end else if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign sqrt_chain[0] = fin_r;

  for (genvar j = 0; j < psd_pkg::SQRT_CELLS; j++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .s_in (sqrt_chain[j]),
      .s_out(sqrt_chain[j+1])
    );
  end

  // the last root cell is the result register
  assign out_tvalid = sqrt_chain[psd_pkg::SQRT_CELLS].valid;
  assign out_tdata  = {7'b0,
                       sqrt_chain[psd_pkg::SQRT_CELLS].near_y,
                       sqrt_chain[psd_pkg::SQRT_CELLS].near_x,
                       sqrt_chain[psd_pkg::SQRT_CELLS].root};
  assign out_tuser  = sqrt_chain[psd_pkg::SQRT_CELLS].region;

  assign dl_endpoint_w  = dl_w.valid && dl_w.region != psd_pkg::REG_INTERIOR;
  assign dl_quo_zero_w  = dl_w.acc_x[psd_pkg::QUO_W-1:0] == '0 &&
                          dl_w.acc_y[psd_pkg::QUO_W-1:0] == '0;
  assign out_endpoint_w = out_tvalid && out_tuser != psd_pkg::REG_INTERIOR;
  assign out_whole_w    = out_tdata[32:25] == 8'd0 && out_tdata[56:49] == 8'd0;

  // the divisor entering the row is never zero, degenerate segments included
  `PSD_ASSERT_NEVER(a_den_nonzero, clk, rst_n, div_chain[0].valid && div_chain[0].den == '0)
  // endpoint cases carry no foot quotient out of the division row
  `PSD_ASSERT(a_foot_zero, clk, rst_n, dl_endpoint_w |-> dl_quo_zero_w)
  // endpoint results are whole coordinates
  `PSD_ASSERT(a_endpoint_whole, clk, rst_n, out_endpoint_w |-> out_whole_w)

endmodule
`default_nettype wire

/* tb/sv/point_segment_distance_tb.sv */
`default_nettype none
// Testbench for point_segment_distance: requests from a queue feed a
// randomly gapped stream, results drain through a randomly stalled consumer,
// and each result is checked against an exact integer model of the geometry.
module point_segment_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [psd_pkg::DIST_W-1:0] distance;
    logic [psd_pkg::NEAR_W-1:0] nearest_x;
    logic [psd_pkg::NEAR_W-1:0] nearest_y;
    psd_pkg::region_t           region;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [95:0] pending_reqs[$];
  answer_t     awaited[$];
  int          mismatches;
  int          results_seen;
  int          region_hits[3];
  int          send_gap;
  int          stall_len;

  point_segment_distance DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Largest r below 2^DIST_W with r^2 * den <= num * 2^(2F).
  function automatic logic [psd_pkg::DIST_W-1:0] scaled_root(logic [127:0] num,
                                                             logic [127:0] den);
    logic [127:0] target;
    logic [127:0] cand;
    logic [psd_pkg::DIST_W-1:0] r;
    target = num << (2 * psd_pkg::FRAC_BITS);
    r = '0;
    for (int b = psd_pkg::DIST_W - 1; b >= 0; b--) begin
      cand = 128'(r) | (128'd1 << b);
      if (cand * cand * den <= target) r = cand[psd_pkg::DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [psd_pkg::NEAR_W-1:0] clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) << (psd_pkg::NEAR_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[psd_pkg::NEAR_W-1:0];
  endfunction

  // Foot of the perpendicular on one axis, floored toward minus infinity.
  function automatic longint foot_coord(longint s, longint d, longint dot, longint len2);
    logic [127:0] num;
    logic [127:0] off;
    logic [127:0] rem;
    longint base;
    num = (128'(dot) * 128'(d < 0 ? -d : d)) << psd_pkg::FRAC_BITS;
    off = num / 128'(len2);
    rem = num % 128'(len2);
    base = s * (longint'(1) << psd_pkg::FRAC_BITS);
    if (d < 0) return base - longint'(off) - (rem != 0 ? 1 : 0);
    return base + longint'(off);
  endfunction

  function automatic answer_t locate_nearest(logic [95:0] req);
    longint sx, sy, ex, ey, qx, qy, dx, dy, px, py, rx, ry, dot, len2, cr;
    answer_t a;
    sx = longint'($signed(req[15:0]));
    sy = longint'($signed(req[31:16]));
    ex = longint'($signed(req[47:32]));
    ey = longint'($signed(req[63:48]));
    qx = longint'($signed(req[79:64]));
    qy = longint'($signed(req[95:80]));
    dx = ex - sx;
    dy = ey - sy;
    px = qx - sx;
    py = qy - sy;
    dot = px * dx + py * dy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0 || dot < 0) begin
      a.distance  = scaled_root(128'(px * px + py * py), 128'd1);
      a.nearest_x = clamp_coord(sx * (longint'(1) << psd_pkg::FRAC_BITS));
      a.nearest_y = clamp_coord(sy * (longint'(1) << psd_pkg::FRAC_BITS));
      a.region    = psd_pkg::REG_START;
    end else if (dot > len2) begin
      rx = qx - ex;
      ry = qy - ey;
      a.distance  = scaled_root(128'(rx * rx + ry * ry), 128'd1);
      a.nearest_x = clamp_coord(ex * (longint'(1) << psd_pkg::FRAC_BITS));
      a.nearest_y = clamp_coord(ey * (longint'(1) << psd_pkg::FRAC_BITS));
      a.region    = psd_pkg::REG_END;
    end else begin
      cr = px * dy - py * dx;
      if (cr < 0) cr = -cr;
      a.distance  = scaled_root(128'(cr) * 128'(cr), 128'(len2));
      a.nearest_x = clamp_coord(foot_coord(sx, dx, dot, len2));
      a.nearest_y = clamp_coord(foot_coord(sy, dy, dot, len2));
      a.region    = psd_pkg::REG_INTERIOR;
    end
    return a;
  endfunction

  function automatic logic [95:0] pack_request(int sx, int sy, int ex, int ey, int qx, int qy);
    return {16'(qy), 16'(qx), 16'(ey), 16'(ex), 16'(sy), 16'(sx)};
  endfunction

  // No gap most of the time, otherwise mostly short gaps, occasionally long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Random coordinate: full range, or a small window so that interior
  // projections and exact feet turn up often.
  function automatic int pick_coord(bit narrow);
    if (narrow) return $signed($urandom_range(0, 64)) - 32;
    return $signed(16'($urandom_range(0, 65535)));
  endfunction

  // Driver: present the next request once the current one is taken, predicting
  // the result of each request at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) awaited.push_back(locate_nearest(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_reqs.pop_front();
          send_gap  <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result channel at random and check each accepted
  // result against the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_len  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (awaited.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h region %0d", out_tdata, out_tuser);
        end else begin
          want = awaited.pop_front();
          region_hits[want.region] <= region_hits[want.region] + 1;
          if (out_tdata[24:0] !== want.distance || out_tdata[48:25] !== want.nearest_x ||
              out_tdata[72:49] !== want.nearest_y || out_tdata[79:73] !== 7'd0 ||
              out_tuser !== want.region) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display(
                "mismatch: exp dist %h nx %h ny %h reg %0d, got dist %h nx %h ny %h reg %0d",
                want.distance, want.nearest_x, want.nearest_y, want.region,
                out_tdata[24:0], out_tdata[48:25], out_tdata[72:49], out_tuser);
          end
        end
      end
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        stall_len  <= stall_len - 1;
      end else begin
        out_tready <= 1'b1;
        stall_len  <= pick_gap();
      end
    end
  end

  initial begin
    int sx, sy, ex, ey, qx, qy, t;
    bit narrow;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    region_hits  = '{0, 0, 0};

    // Directed: degenerate segment, before start, past end, projection
    // landing exactly on the end, interior with negative direction, extremes.
    pending_reqs.push_back(pack_request(0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(pack_request(5, -7, 5, -7, 100, 3));
    pending_reqs.push_back(pack_request(-32768, -32768, -32768, -32768, 32767, 32767));
    pending_reqs.push_back(pack_request(0, 0, 10, 0, -5, 3));
    pending_reqs.push_back(pack_request(0, 0, 10, 0, 15, -3));
    pending_reqs.push_back(pack_request(0, 0, 10, 0, 10, 7));
    pending_reqs.push_back(pack_request(0, 0, 10, 0, 0, 7));
    pending_reqs.push_back(pack_request(0, 0, 3, 7, 2, 1));
    pending_reqs.push_back(pack_request(10, 10, -3, 4, 1, 9));
    pending_reqs.push_back(pack_request(32767, 32767, -32768, -32768, 32767, -32768));
    pending_reqs.push_back(pack_request(-32768, 32767, 32767, -32768, -32768, -32768));
    pending_reqs.push_back(pack_request(-32768, -32768, 32767, 32767, 32767, -32768));
    pending_reqs.push_back(pack_request(-32768, -32768, -32767, -32768, 32767, 32767));
    pending_reqs.push_back(pack_request(32767, 32767, 32767, -32768, -32768, 0));
    pending_reqs.push_back(pack_request(-32768, 0, 32767, 1, 0, 32767));
    pending_reqs.push_back(pack_request(1, 2, 4, 6, 4, 6));
    pending_reqs.push_back(pack_request(-1, -1, -1, -1, -1, -1));
    pending_reqs.push_back(pack_request(0, 0, -7, -3, -1, -5));

    // Random: half small windows, half full range; some queries sit near
    // the segment so that interior projections dominate.
    for (int i = 0; i < 1232; i++) begin
      narrow = $urandom_range(1);
      sx = pick_coord(narrow);
      sy = pick_coord(narrow);
      ex = pick_coord(narrow);
      ey = pick_coord(narrow);
      if ($urandom_range(2) == 0) begin
        t  = $urandom_range(0, 16);
        qx = sx + ((ex - sx) * t) / 16 + $signed($urandom_range(0, 8)) - 4;
        qy = sy + ((ey - sy) * t) / 16 + $signed($urandom_range(0, 8)) - 4;
        if (qx > 32767) qx = 32767;
        if (qx < -32768) qx = -32768;
        if (qy > 32767) qy = 32767;
        if (qy < -32768) qy = -32768;
      end else begin
        qx = pick_coord(narrow);
        qy = pick_coord(narrow);
      end
      pending_reqs.push_back(pack_request(sx, sy, ex, ey, qx, qy));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every request taken, every prediction matched, then a margin
    // beyond the pipeline depth for any stray result.
    while (pending_reqs.size() > 0 || in_tvalid || awaited.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("checked %0d results: %0d before start or degenerate, %0d past end, %0d interior",
             results_seen, region_hits[0], region_hits[1], region_hits[2]);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timed out with %0d results outstanding", awaited.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
